// ----- rtl/core/particle_boundary_collision_core_macros.svh -----
// Assertion macros for the particle boundary collision core.
`ifndef PARTICLE_BOUNDARY_COLLISION_CORE_MACROS_SVH
`define PARTICLE_BOUNDARY_COLLISION_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbc assertion failed");
`define PBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbc assertion failed");
`else
`define PBC_ASSERT_NOW(label, ante, cons)
`define PBC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/pbc_pkg.sv -----
// Shared types, constants and helpers of the particle boundary collision core.
`default_nettype none
package pbc_pkg;
  localparam int MAX_OBSTACLES = 8;
  localparam int CFG_W = 29;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_EXT   = 2'd1;
  localparam logic [1:0] KIND_INT   = 2'd2;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_BOUNCE = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } particle_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] rad;
  } obst_t;

  typedef struct packed {
    logic [24:0] radius;
    logic [16:0] bounce;
    logic [28:0] width;
    logic [28:0] height;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/pbc_if.sv -----
// Valid/ready channel interfaces for particle items and result words.
`default_nettype none
interface pbc_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [2:0]         slot;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic [1:0]         obstacle_kind;
  modport source (output valid, mode, slot, x_value, y_value, vel_x, vel_y, obstacle_kind,
                  input ready);
  modport sink (input valid, mode, slot, x_value, y_value, vel_x, vel_y, obstacle_kind,
                output ready);
endinterface

interface pbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pbc_wall.sv -----
// Wall clamp and bounce stage: the clamp and the bounce product are registered, then the output word.
`default_nettype none
module pbc_wall (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  pbc_pkg::particle_t  in_data,
  input  pbc_pkg::cfg_t       cfg,
  output logic                out_valid,
  output pbc_pkg::particle_t  out_data
);
  import pbc_pkg::*;

  logic               s1_valid;
  particle_t          s1;
  logic               hitx, hity;
  logic signed [49:0] prodx, prody;
  logic signed [63:0] r64, px64, py64, wx64, hy64;
  logic signed [31:0] px_next, py_next;
  logic               hitx_next, hity_next;

  always_comb begin
    r64  = 64'($signed({1'b0, cfg.radius}));
    px64 = 64'(in_data.px);
    py64 = 64'(in_data.py);
    wx64 = 64'($signed({1'b0, cfg.width}));
    hy64 = 64'($signed({1'b0, cfg.height}));
    hitx_next = 1'b1;
    hity_next = 1'b1;
    if (px64 < r64) px_next = r64[31:0];
    else if (px64 + r64 > wx64) px_next = sat32(wx64 - r64);
    else begin
      px_next = in_data.px;
      hitx_next = 1'b0;
    end
    if (py64 < r64) py_next = r64[31:0];
    else if (py64 + r64 > hy64) py_next = sat32(hy64 - r64);
    else begin
      py_next = in_data.py;
      hity_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
    s1.px <= px_next;
    s1.py <= py_next;
    s1.vx <= in_data.vx;
    s1.vy <= in_data.vy;
    hitx  <= hitx_next;
    hity  <= hity_next;
    prodx <= in_data.vx * $signed({1'b0, cfg.bounce});
    prody <= in_data.vy * $signed({1'b0, cfg.bounce});
    out_data.px <= s1.px;
    out_data.py <= s1.py;
    out_data.vx <= hitx ? sat32((-64'(prodx)) >>> 16) : s1.vx;
    out_data.vy <= hity ? sat32((-64'(prody)) >>> 16) : s1.vy;
  end
endmodule
`default_nettype wire

// ----- rtl/core/pbc_cell.sv -----
// One obstacle cell: holds a slot and corrects the particle word passing through.
`default_nettype none
module pbc_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 wr_en,
  input  pbc_pkg::obst_t      wr_data,
  input  wire  [24:0]         radius,
  input  wire                 in_valid,
  input  pbc_pkg::particle_t  in_data,
  output logic                out_valid,
  output pbc_pkg::particle_t  out_data
);
  import pbc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_MULP = 4'd6;
  localparam logic [3:0] S_POS  = 4'd7;
  localparam logic [3:0] S_MULV = 4'd8;
  localparam logic [3:0] S_VEL  = 4'd9;

  obst_t              obst;
  logic [3:0]         state;
  logic [4:0]         cnt;
  logic [31:0]        ax, ay;
  logic               sgnx, sgny, sh;
  logic [63:0]        sq, res, bitv;
  logic signed [34:0] ov;
  logic [48:0]        dvr;
  logic [47:0]        remx, remy;
  logic [16:0]        qx, qy;
  logic signed [17:0] nx, ny;
  logic signed [52:0] pmx, pmy;
  logic signed [49:0] dvx, dvy;
  logic signed [34:0] dot;
  logic signed [53:0] qvx, qvy;

  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [63:0]        trial;
  logic [31:0]        ds;
  logic [32:0]        span;
  logic signed [34:0] ov_next;
  logic               gex, gey;
  logic [16:0]        qx_next, qy_next;
  logic signed [50:0] dsum;

  always_comb begin
    dx  = 33'(in_data.px) - 33'(obst.cx);
    dy  = 33'(in_data.py) - 33'(obst.cy);
    adx = dx[32] ? 33'(-dx) : 33'(dx);
    ady = dy[32] ? 33'(-dy) : 33'(dy);
    trial = res + bitv;
    ds   = res[31:0];
    span = sh ? {ds, 1'b0} : {1'b0, ds};
    ov_next = 35'($signed({1'b0, radius})) + 35'(obst.rad) - $signed({2'b0, span});
    gex = {1'b0, remx} >= dvr;
    gey = {1'b0, remy} >= dvr;
    qx_next = {qx[15:0], gex};
    qy_next = {qy[15:0], gey};
    dsum = 51'(dvx) + 51'(dvy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obst.kind <= KIND_EMPTY;
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (wr_en) obst <= wr_data;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (obst.kind == KIND_EXT || obst.kind == KIND_INT) state <= S_SQX;
            else out_valid <= 1'b1;
          end
        end
        S_SQX:  state <= S_SQY;
        S_SQY: begin
          cnt   <= 5'd31;
          state <= S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) state <= S_CHK;
        end
        S_CHK: begin
          if (obst.kind == KIND_EXT ? !(ov_next > 0) : !(ov_next < 0)) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (ds == 32'd0) state <= S_MULP;
          else begin
            cnt   <= 5'd16;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) state <= S_MULP;
        end
        S_MULP: state <= S_POS;
        S_POS:  state <= S_MULV;
        S_MULV: begin
          if (dot < 0) state <= S_VEL;
          else begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_VEL: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        out_data <= in_data;
        sgnx <= dx[32];
        sgny <= dy[32];
        // halve both offsets when either needs the top bit
        if (adx[32] | adx[31] | ady[32] | ady[31]) begin
          ax <= adx[32:1];
          ay <= ady[32:1];
          sh <= 1'b1;
        end else begin
          ax <= adx[31:0];
          ay <= ady[31:0];
          sh <= 1'b0;
        end
      end
      S_SQX: sq <= ax * ax;
      S_SQY: begin
        sq   <= sq + ay * ay;
        res  <= 64'd0;
        bitv <= 64'h4000000000000000;
      end
      S_SQRT: begin
        if (sq >= trial) begin
          sq  <= sq - trial;
          res <= (res >> 1) + bitv;
        end else res <= res >> 1;
        bitv <= bitv >> 2;
      end
      S_CHK: begin
        ov   <= ov_next;
        nx   <= 18'sd0;
        ny   <= 18'sd0;
        dvr  <= {1'b0, ds, 16'd0};
        remx <= {ax, 16'd0};
        remy <= {ay, 16'd0};
        qx   <= 17'd0;
        qy   <= 17'd0;
      end
      S_DIV: begin
        if (gex) remx <= remx - dvr[47:0];
        if (gey) remy <= remy - dvr[47:0];
        dvr <= dvr >> 1;
        qx  <= qx_next;
        qy  <= qy_next;
        if (cnt == 5'd0) begin
          nx <= sgnx ? -$signed({1'b0, qx_next}) : $signed({1'b0, qx_next});
          ny <= sgny ? -$signed({1'b0, qy_next}) : $signed({1'b0, qy_next});
        end
      end
      S_MULP: begin
        pmx <= nx * ov;
        pmy <= ny * ov;
        dvx <= out_data.vx * nx;
        dvy <= out_data.vy * ny;
      end
      S_POS: begin
        out_data.px <= sat32(64'(out_data.px) + 64'(pmx >>> 16));
        out_data.py <= sat32(64'(out_data.py) + 64'(pmy >>> 16));
        dot <= dsum[50:16];
      end
      S_MULV: begin
        qvx <= nx * $signed({dot, 1'b0});
        qvy <= ny * $signed({dot, 1'b0});
      end
      S_VEL: begin
        out_data.vx <= sat32(64'(out_data.vx) - 64'(qvx >>> 16));
        out_data.vy <= sat32(64'(out_data.vy) - 64'(qvy >>> 16));
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/particle_boundary_collision_core.sv -----
// Top level: configuration, wall stage, chain of obstacle cells, result register.
//
//  channel   dir  handshake      word
//  in_ch     in   valid/ready    mode, slot, x_value, y_value, vel_x, vel_y, obstacle_kind
//  out_ch    out  valid/ready    new_pos_x, new_pos_y, new_vel_x, new_vel_y
//  cfg       in   cfg_wr_en      cfg_index, cfg_data
//
// A mode 0 word writes its cell and gives no result.
// A mode 1 word passes the wall stage, then each cell: an empty cell passes it on, an
// occupied one runs the squares, a 32-step square root and the overlap check, and on a hit
// a 17-step divide (skipped for a zero direction) and the corrections; then pend and out_ch.
// One particle is in flight at a time; in_ch.ready is low until its result is registered.
// Reset (rst, synchronous) empties every obstacle slot and loads the default registers.
`default_nettype none
`include "particle_boundary_collision_core_macros.svh"
module particle_boundary_collision_core #(
  parameter int MAX_OBSTACLES = pbc_pkg::MAX_OBSTACLES
) (
  input  wire                        clk,
  input  wire                        rst,
  pbc_in_if.sink                     in_ch,
  pbc_out_if.source                  out_ch,
  input  wire                        cfg_wr_en,
  input  wire  [1:0]                 cfg_index,
  input  wire  [pbc_pkg::CFG_W-1:0]  cfg_data
);
  import pbc_pkg::*;

  cfg_t      cfg;
  logic      busy;
  logic      pend_v;
  particle_t pend;
  logic      in_acc, part_start;
  particle_t in_word;
  obst_t     wr_word;
  logic      wall_v;
  particle_t wall_d;
  logic      chain_v [MAX_OBSTACLES+1];
  particle_t chain_d [MAX_OBSTACLES+1];

  assign in_ch.ready = !busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign part_start  = in_acc && in_ch.mode;
  assign in_word     = '{px: in_ch.x_value, py: in_ch.y_value,
                         vx: in_ch.vel_x, vy: in_ch.vel_y};
  assign wr_word     = '{kind: in_ch.obstacle_kind, cx: in_ch.x_value,
                         cy: in_ch.y_value, rad: in_ch.vel_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius <= 25'd327680;
      cfg.bounce <= 17'd32768;
      cfg.width  <= 29'd52428800;
      cfg.height <= 29'd39321600;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RADIUS: cfg.radius <= cfg_data[24:0];
        REG_BOUNCE: cfg.bounce <= cfg_data[16:0];
        REG_WIDTH:  cfg.width  <= cfg_data;
        REG_HEIGHT: cfg.height <= cfg_data;
        default: ;
      endcase
    end
  end

  pbc_wall u_wall (
    .clk, .rst,
    .in_valid (part_start),
    .in_data  (in_word),
    .cfg,
    .out_valid(wall_v),
    .out_data (wall_d)
  );

  assign chain_v[0] = wall_v;
  assign chain_d[0] = wall_d;

  for (genvar k = 0; k < MAX_OBSTACLES; k++) begin : g_cell
    pbc_cell u_cell (
      .clk, .rst,
      .wr_en    (in_acc && !in_ch.mode && 32'(in_ch.slot) == k),
      .wr_data  (wr_word),
      .radius   (cfg.radius),
      .in_valid (chain_v[k]),
      .in_data  (chain_d[k]),
      .out_valid(chain_v[k+1]),
      .out_data (chain_d[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pend_v       <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (part_start) busy <= 1'b1;
      if (chain_v[MAX_OBSTACLES]) pend_v <= 1'b1;
      if (pend_v && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
        pend_v       <= 1'b0;
        busy         <= 1'b0;
      end else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_v[MAX_OBSTACLES]) pend <= chain_d[MAX_OBSTACLES];
    if (pend_v && (!out_ch.valid || out_ch.ready)) begin
      out_ch.new_pos_x <= pend.px;
      out_ch.new_pos_y <= pend.py;
      out_ch.new_vel_x <= pend.vx;
      out_ch.new_vel_y <= pend.vy;
    end
  end

  `PBC_ASSERT_NOW(a_wall_busy, wall_v, busy)
  `PBC_ASSERT_NOW(a_pend_busy, pend_v, busy)
  `PBC_ASSERT_NOW(a_one_word, 1'b1, $onehot0({wall_v, pend_v, chain_v[MAX_OBSTACLES]}))
  `PBC_ASSERT_NEXT(a_start_busy, part_start, busy && !in_ch.ready)
endmodule
`default_nettype wire

// ----- test/particle_boundary_collision_core_tb.sv -----
// Self-checking testbench for the particle boundary collision core.
`default_nettype none
module particle_boundary_collision_core_tb;
  import pbc_pkg::*;

  typedef struct {
    logic               mode;
    logic [2:0]         slot;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [1:0]         kind;
  } in_word_t;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     SETTLE_CYCLES = 600;
  localparam int     PX = 65536;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [1:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  pbc_in_if  in_ch ();
  pbc_out_if out_ch ();

  particle_boundary_collision_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  obst_t     obst_slots [MAX_OBSTACLES];
  cfg_t      area_cfg;
  particle_t results_due [$];

  int        send_idle_pct;
  int        recv_idle_pct;
  int        failures;
  int        particles_sent;
  int        slot_writes;
  int        reg_writes;
  int        results_seen;
  longint    cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Clamp one axis against its two walls and damp the velocity on a hit.
  function automatic void clamp_axis(inout longint p, inout longint v, input longint lim);
    longint r;
    longint b;
    bit     hit;
    r   = longint'(area_cfg.radius);
    b   = longint'(area_cfg.bounce);
    hit = 1'b0;
    if (p < r) begin
      p   = r;
      hit = 1'b1;
    end else if (p + r > lim) begin
      p   = clip32(lim - r);
      hit = 1'b1;
    end
    if (hit) v = clip32(-(v * b) >>> 16);
  endfunction

  function automatic particle_t collide(input in_word_t w);
    particle_t     res;
    longint        px, py, vx, vy, r, dx, dy, nx, ny, span, overlap, dot;
    longint unsigned ax, ay, ds;
    int            sh;
    px = longint'(w.x_value);
    py = longint'(w.y_value);
    vx = longint'(w.vel_x);
    vy = longint'(w.vel_y);
    r  = longint'(area_cfg.radius);
    clamp_axis(px, vx, longint'(area_cfg.width));
    clamp_axis(py, vy, longint'(area_cfg.height));
    for (int k = 0; k < MAX_OBSTACLES; k++) begin
      if (obst_slots[k].kind != KIND_EXT && obst_slots[k].kind != KIND_INT) continue;
      dx = px - longint'(obst_slots[k].cx);
      dy = py - longint'(obst_slots[k].cy);
      ax = (dx < 0) ? longint'(-dx) : dx;
      ay = (dy < 0) ? longint'(-dy) : dy;
      sh = 0;
      // halve very large offsets so the squares stay in range
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
        ax = ax >> 1;
        ay = ay >> 1;
        sh = 1;
      end
      ds      = root64(ax * ax + ay * ay);
      span    = longint'(ds << sh);
      overlap = r + longint'(obst_slots[k].rad) - span;
      if (obst_slots[k].kind == KIND_EXT ? !(overlap > 0) : !(overlap < 0)) continue;
      nx = 0;
      ny = 0;
      if (ds != 0) begin
        nx = longint'((ax << 16) / ds);
        ny = longint'((ay << 16) / ds);
        if (dx < 0) nx = -nx;
        if (dy < 0) ny = -ny;
      end
      px  = clip32(px + ((nx * overlap) >>> 16));
      py  = clip32(py + ((ny * overlap) >>> 16));
      dot = (vx * nx + vy * ny) >>> 16;
      if (dot < 0) begin
        vx = clip32(vx - ((nx * 2 * dot) >>> 16));
        vy = clip32(vy - ((ny * 2 * dot) >>> 16));
      end
    end
    res.px = px[31:0];
    res.py = py[31:0];
    res.vx = vx[31:0];
    res.vy = vy[31:0];
    return res;
  endfunction

  function automatic void accept_word(input in_word_t w);
    if (w.mode == 1'b0) begin
      slot_writes++;
      if (int'(w.slot) < MAX_OBSTACLES) begin
        obst_slots[w.slot].kind = w.kind;
        obst_slots[w.slot].cx   = w.x_value;
        obst_slots[w.slot].cy   = w.y_value;
        obst_slots[w.slot].rad  = w.vel_x;
      end
    end else begin
      particles_sent++;
      results_due.insert(results_due.size(), collide(w));
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input in_word_t w);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= w.mode;
    in_ch.slot          <= w.slot;
    in_ch.x_value       <= w.x_value;
    in_ch.y_value       <= w.y_value;
    in_ch.vel_x         <= w.vel_x;
    in_ch.vel_y         <= w.vel_y;
    in_ch.obstacle_kind <= w.kind;
    do @(posedge clk); while (!in_ch.ready);
    accept_word(w);
    @(negedge clk);
  endtask

  // Hold the sender until every result is back, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
    case (idx)
      REG_RADIUS: area_cfg.radius = val[24:0];
      REG_BOUNCE: area_cfg.bounce = val[16:0];
      REG_WIDTH:  area_cfg.width  = val[28:0];
      REG_HEIGHT: area_cfg.height = val[28:0];
      default: ;
    endcase
  endtask

  function automatic in_word_t particle_word(input int x, input int y, input int vx,
                                             input int vy);
    in_word_t w;
    w.mode = 1'b1; w.slot = 3'($urandom); w.kind = 2'($urandom);
    w.x_value = x; w.y_value = y; w.vel_x = vx; w.vel_y = vy;
    return w;
  endfunction

  function automatic in_word_t slot_word(input int s, input logic [1:0] k, input int cx,
                                         input int cy, input int rad);
    in_word_t w;
    w.mode = 1'b0; w.slot = 3'(s); w.kind = k;
    w.x_value = cx; w.y_value = cy; w.vel_x = rad; w.vel_y = int'($urandom);
    return w;
  endfunction

  function automatic int in_area(input longint lim);
    return int'($urandom_range(32'(lim + 20 * PX))) - 10 * PX;
  endfunction

  function automatic int small_vel();
    return int'($urandom_range(1 << 22)) - (1 << 21);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    int       s;
    int       spread;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // obstacle in the area, mostly sensible radii, sometimes empty or kind 3
      w = slot_word($urandom_range(7), 2'($urandom), in_area(area_cfg.width),
                    in_area(area_cfg.height), $urandom_range(80 * PX));
    end else if (pick < 52) begin
      // particle close to a slot centre, where hits are likely
      s = $urandom_range(MAX_OBSTACLES - 1);
      spread = int'(obst_slots[s].rad) + 2 * int'(area_cfg.radius) + 4 * PX;
      if (spread <= 0 || spread > (1 << 28)) spread = 64 * PX;
      w = particle_word(int'(obst_slots[s].cx) + int'($urandom_range(2 * spread)) - spread,
                        int'(obst_slots[s].cy) + int'($urandom_range(2 * spread)) - spread,
                        small_vel(), small_vel());
    end else if (pick < 88) begin
      w = particle_word(in_area(area_cfg.width), in_area(area_cfg.height),
                        small_vel(), small_vel());
    end else begin
      // noise over the whole of every field
      w.mode = 1'($urandom); w.slot = 3'($urandom); w.kind = 2'($urandom);
      w.x_value = $urandom; w.y_value = $urandom; w.vel_x = $urandom; w.vel_y = $urandom;
    end
    return w;
  endfunction

  task automatic test_walls();
    send_word(particle_word(0, 0, 32'sh7fffffff, -32'sh7fffffff - 1));
    send_word(particle_word(32'sh7fffffff, 32'sh7fffffff, -32'sh7fffffff - 1, 32'sh7fffffff));
    send_word(particle_word(-32'sh7fffffff - 1, -32'sh7fffffff - 1, -1, 1));
    send_word(particle_word(5 * PX, 5 * PX, 3 * PX, -3 * PX));
    send_word(particle_word(400 * PX, 300 * PX, 0, 0));
  endtask

  task automatic test_obstacles();
    send_word(slot_word(0, KIND_EXT, 100 * PX, 100 * PX, 20 * PX));
    send_word(particle_word(105 * PX, 100 * PX, -4 * PX, PX));
    // particle exactly on the centre: zero direction
    send_word(particle_word(100 * PX, 100 * PX, 2 * PX, 2 * PX));
    send_word(slot_word(1, KIND_INT, 200 * PX, 150 * PX, 100 * PX));
    send_word(particle_word(350 * PX, 150 * PX, 5 * PX, -PX));
    send_word(slot_word(2, 2'd3, 300 * PX, 200 * PX, 50 * PX));
    send_word(particle_word(300 * PX, 200 * PX, PX, PX));
    // centre far outside: offsets of 2^31 and more
    send_word(slot_word(7, KIND_EXT, -32'sh7fffffff - 1, -32'sh7fffffff - 1, 32'sh7fffffff));
    send_word(particle_word(700 * PX, 500 * PX, -PX, -PX));
    send_word(slot_word(7, KIND_INT, 32'sh7fffffff, -32'sh7fffffff - 1, -32'sh7fffffff - 1));
    send_word(particle_word(30 * PX, 30 * PX, PX, -PX));
    send_word(slot_word(3, KIND_EXT, 50 * PX, 50 * PX, -10 * PX));
    send_word(particle_word(50 * PX, 52 * PX, 0, -PX));
    for (int s = 0; s < MAX_OBSTACLES; s++) send_word(slot_word(s, KIND_EMPTY, 0, 0, 0));
  endtask

  task automatic test_reg_extremes();
    write_reg(REG_RADIUS, 29'd16777216);
    write_reg(REG_BOUNCE, 29'd65536);
    write_reg(REG_WIDTH, 29'd65536);
    write_reg(REG_HEIGHT, 29'd268435456);
    send_word(particle_word(0, 32'sh7fffffff, 5 * PX, 5 * PX));
    send_word(particle_word(100 * PX, -PX, -32'sh7fffffff - 1, 32'sh7fffffff));
    write_reg(REG_RADIUS, 29'd0);
    write_reg(REG_BOUNCE, 29'h1fffffff);
    write_reg(REG_WIDTH, 29'h1fffffff);
    write_reg(REG_HEIGHT, 29'd65536);
    send_word(particle_word(-1, 2 * PX, 7 * PX, -7 * PX));
    write_reg(REG_BOUNCE, 29'd0);
    send_word(particle_word(-PX, -PX, 7 * PX, -7 * PX));
  endtask

  task automatic test_random(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain();
      send_word(random_word());
    end
  endtask

  task automatic random_regs();
    write_reg(REG_RADIUS, 29'($urandom_range(12 * PX)));
    write_reg(REG_BOUNCE, 29'($urandom_range(65536)));
    write_reg(REG_WIDTH, 29'($urandom_range(1000 * PX, 100 * PX)));
    write_reg(REG_HEIGHT, 29'($urandom_range(800 * PX, 80 * PX)));
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    particle_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        failures++;
        $display("%0t unexpected result: expected none actual %h %h %h %h", $time,
                 out_ch.new_pos_x, out_ch.new_pos_y, out_ch.new_vel_x, out_ch.new_vel_y);
      end else begin
        want = results_due.pop_front();
        check_field("new_pos_x", want.px, out_ch.new_pos_x);
        check_field("new_pos_y", want.py, out_ch.new_pos_y);
        check_field("new_vel_x", want.vx, out_ch.new_vel_x);
        check_field("new_vel_y", want.vy, out_ch.new_vel_y);
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("particle_boundary_collision_core_tb failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_RADIUS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.slot = '0;
    in_ch.x_value = '0;
    in_ch.y_value = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.obstacle_kind = KIND_EMPTY;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    failures = 0;
    particles_sent = 0;
    slot_writes = 0;
    reg_writes = 0;
    results_seen = 0;
    cycles = 0;
    for (int s = 0; s < MAX_OBSTACLES; s++) obst_slots[s] = '0;
    area_cfg.radius = 25'd327680;
    area_cfg.bounce = 17'd32768;
    area_cfg.width  = 29'd52428800;
    area_cfg.height = 29'd39321600;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_walls();
    test_obstacles();
    test_reg_extremes();

    random_regs();
    send_idle_pct = 31; recv_idle_pct = 60;
    test_random(570, 1'b1);
    random_regs();
    send_idle_pct = 60; recv_idle_pct = 31;
    test_random(570, 1'b0);
    write_reg(REG_RADIUS, 29'd327680);
    write_reg(REG_BOUNCE, 29'd32768);
    write_reg(REG_WIDTH, 29'd52428800);
    write_reg(REG_HEIGHT, 29'd39321600);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(570, 1'b0);

    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("run: %0d particles, %0d results, %0d slot writes, %0d register writes",
             particles_sent, results_seen, slot_writes, reg_writes);
    $display("walls, circle hits, zero and huge offsets, register extremes, three idle mixes");
    if (failures == 0) begin
      $display("particle_boundary_collision_core_tb passed");
    end else begin
      $display("particle_boundary_collision_core_tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
